>>> src/aes_pkg.sv
//------------------------------------------------------------------------------
// AES-128 package
// S-box table, round constants and byte-level helper functions.
//------------------------------------------------------------------------------
`default_nettype none

package aes_pkg;

  localparam int unsigned RoundCount = 10;
  localparam int unsigned KeyCount   = RoundCount + 1;
  localparam int unsigned StoreDepth = 2 * KeyCount;
  localparam int unsigned BlockBytes = 16;
  localparam int unsigned KeyBytes   = BlockBytes * KeyCount;

  localparam logic [0:0] CFG_KEY_HIGH = 1'b0;
  localparam logic [0:0] CFG_KEY_LOW  = 1'b1;

  typedef logic [127:0] block_t;
  typedef block_t       rkey_arr_t [KeyCount];

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [RoundCount] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  function automatic logic [7:0] xtime(input logic [7:0] v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Byte i of the block (message order) sits in bits 127-8i downto 120-8i.
  function automatic logic [7:0] get_byte(input block_t b, input int unsigned i);
    get_byte = b[127 - 8*i -: 8];
  endfunction

  function automatic block_t sub_shift(input block_t s);
    block_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(c*4 + r) -: 8] = SBOX[get_byte(s, ((c + r) % 4) * 4 + r)];
      end
    end
    sub_shift = t;
  endfunction

  function automatic block_t mix(input block_t s);
    block_t     t;
    logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c + 1);
      a2 = get_byte(s, 4*c + 2);
      a3 = get_byte(s, 4*c + 3);
      d0 = xtime(a0);
      d1 = xtime(a1);
      d2 = xtime(a2);
      d3 = xtime(a3);
      t[127 - 8*(4*c) -: 8]     = d0 ^ d1 ^ a1 ^ a2 ^ a3;
      t[127 - 8*(4*c + 1) -: 8] = a0 ^ d1 ^ d2 ^ a2 ^ a3;
      t[127 - 8*(4*c + 2) -: 8] = a0 ^ a1 ^ d2 ^ d3 ^ a3;
      t[127 - 8*(4*c + 3) -: 8] = d0 ^ a0 ^ a1 ^ a2 ^ d3;
    end
    mix = t;
  endfunction

  // One step of the AES-128 key schedule.
  function automatic block_t next_key(input block_t k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t  = sub_word({w3[23:0], w3[31:24]}) ^ {rc, 24'h0};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    next_key = {w0, w1, w2, w3};
  endfunction

endpackage

`default_nettype wire

>>> src/aes_key_exp.sv
//------------------------------------------------------------------------------
// AES-128 key expansion
// Holds the cipher key and expands it, one round key per cycle, into the
// round key registers. A busy flag is high while the sweep runs.
//------------------------------------------------------------------------------
`default_nettype none

module aes_key_exp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [0:0]           cfg_idx,
  input  wire logic                 cfg_valid_idx,
  input  wire logic [63:0]          cfg_data,
  output aes_pkg::rkey_arr_t        round_keys,
  output logic                      busy
);
  import aes_pkg::*;

  localparam int unsigned CntW = $clog2(KeyCount);

  logic [63:0]     key_high_r, key_low_r;
  rkey_arr_t       rk_r;
  logic [CntW-1:0] step_r;
  logic            busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
      busy_r     <= 1'b1;
      step_r     <= '0;
    end else if (cfg_wr_en && cfg_valid_idx) begin
      unique case (cfg_idx)
        CFG_KEY_HIGH: key_high_r <= cfg_data;
        CFG_KEY_LOW:  key_low_r  <= cfg_data;
        default:      key_low_r  <= key_low_r;
      endcase
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      if (step_r == CntW'(KeyCount - 1)) begin
        busy_r <= 1'b0;
      end else begin
        step_r <= step_r + 1'b1;
      end
    end
  end

  // Step 0 loads the key, step k derives round key k from key k-1.
  always_ff @(posedge clk) begin
    if (busy_r && !(cfg_wr_en && cfg_valid_idx)) begin
      if (step_r == '0) begin
        rk_r[0] <= {key_high_r, key_low_r};
      end else begin
        rk_r[step_r] <= next_key(rk_r[step_r - 1'b1], RCON[step_r - 1'b1]);
      end
    end
  end

  assign round_keys = rk_r;
  assign busy       = busy_r;

endmodule

`default_nettype wire

>>> src/aes_round.sv
//------------------------------------------------------------------------------
// AES round stage
// One registered cipher round with valid and flag riding along; the stage
// holds while its output is stalled.
//------------------------------------------------------------------------------
`default_nettype none

module aes_round #(
  parameter bit FinalRound = 1'b0
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           advance,
  input  wire logic           in_vld,
  input  wire aes_pkg::block_t in_state,
  input  wire logic           in_flag,
  input  wire aes_pkg::block_t round_key,
  output logic                out_vld,
  output aes_pkg::block_t     out_state,
  output logic                out_flag
);
  import aes_pkg::*;

  logic   vld_r, flag_r;
  block_t state_r, state_nxt;

  always_comb begin
    if (FinalRound) begin
      state_nxt = sub_shift(in_state) ^ round_key;
    end else begin
      state_nxt = mix(sub_shift(in_state)) ^ round_key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (advance) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      state_r <= state_nxt;
      flag_r  <= in_flag;
    end
  end

  assign out_vld   = vld_r;
  assign out_state = state_r;
  assign out_flag  = flag_r;

endmodule

`default_nettype wire

>>> src/aes128_block_encrypt.sv
//------------------------------------------------------------------------------
// AES-128 ECB encryption engine
// Encrypts 128-bit blocks in a fully unrolled pipeline, one block per cycle unless stalled.
//------------------------------------------------------------------------------
// Usage:
//   in_tdata  = {plain_high, plain_low} (low half = plain_low), in_tuser = last
//   out_tdata = {cipher_high, cipher_low}, out_tuser = end-of-message copy.
//   Key: cfg index 0 = key_high, index 1 = key_low. Write only when idle.
// Pipeline: one stage for the initial key add, ten round stages and one
//   output register.
// Throughput: one block per cycle unless stalled; each round is one register stage.
// After reset, and after each key write, the key schedule runs through the
//   round keys (one round key a cycle); in_tready is low during that sweep.
// When the receiver stalls with a valid output, every stage holds, empty
//   ones included, and in_tready drops in the same cycle (it follows
//   out_tready combinationally); no item is lost or repeated.
//------------------------------------------------------------------------------
`default_nettype none

module aes128_block_encrypt (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // plain_low [63:0], plain_high [127:64]
  input  wire logic         in_tuser,   // last_block
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [127:0]      out_tdata,  // cipher_low [63:0], cipher_high [127:64]
  output logic              out_tuser,  // end_of_message
  input  wire logic         cfg_wr_en,
  input  wire logic [0:0]   cfg_addr,
  input  wire logic [63:0]  cfg_wdata
);
  import aes_pkg::*;

  localparam int unsigned Stages = RoundCount + 1;

  rkey_arr_t round_keys;
  logic      ks_busy;
  logic      advance;

  logic   vld   [Stages + 1];
  block_t st    [Stages + 1];
  logic   flag  [Stages + 1];

  aes_key_exp u_key_exp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_idx      (cfg_addr),
    .cfg_valid_idx(1'b1),
    .cfg_data     (cfg_wdata),
    .round_keys   (round_keys),
    .busy         (ks_busy)
  );

  // Advance whenever the last stage is empty or is being drained.
  assign advance   = !vld[Stages] || out_tready;
  assign in_tready = advance && !ks_busy;

  // Initial AddRoundKey stage.
  logic   v0_r, f0_r;
  block_t s0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (advance) begin
      v0_r <= in_tvalid && in_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s0_r <= in_tdata ^ round_keys[0];
      f0_r <= in_tuser;
    end
  end

  assign vld[0]  = v0_r;
  assign st[0]   = s0_r;
  assign flag[0] = f0_r;

  for (genvar n = 1; n <= Stages - 1; n++) begin : g_round
    aes_round #(.FinalRound(n == Stages - 1)) u_round (
      .clk      (clk),
      .rst_n    (rst_n),
      .advance  (advance),
      .in_vld   (vld[n-1]),
      .in_state (st[n-1]),
      .in_flag  (flag[n-1]),
      .round_key(round_keys[n]),
      .out_vld  (vld[n]),
      .out_state(st[n]),
      .out_flag (flag[n])
    );
  end

  // Output register.
  logic   vo_r, fo_r;
  block_t so_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (advance) begin
      vo_r <= vld[Stages - 1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      so_r <= st[Stages - 1];
      fo_r <= flag[Stages - 1];
    end
  end

  assign vld[Stages]  = vo_r;
  assign st[Stages]   = so_r;
  assign flag[Stages] = fo_r;

  assign out_tvalid = vo_r;
  assign out_tdata  = so_r;
  assign out_tuser  = fo_r;

endmodule

`default_nettype wire
